### design/jts_pkg.sv
// Shared types, codes and the character classifier for the JSON token scanner.
// No dependencies; every other file of the block refers to this package by scoped names.
package jts_pkg;

   localparam int POS_WIDTH_DEF = 32;
   localparam int IN_DEPTH      = 4;
   localparam int OUT_DEPTH     = 4;

   localparam logic [3:0] KIND_EOF      = 4'd0;
   localparam logic [3:0] KIND_LBRACKET = 4'd1;
   localparam logic [3:0] KIND_RBRACKET = 4'd2;
   localparam logic [3:0] KIND_LBRACE   = 4'd3;
   localparam logic [3:0] KIND_RBRACE   = 4'd4;
   localparam logic [3:0] KIND_COMMA    = 4'd5;
   localparam logic [3:0] KIND_COLON    = 4'd6;
   localparam logic [3:0] KIND_NULL     = 4'd7;
   localparam logic [3:0] KIND_FALSE    = 4'd8;
   localparam logic [3:0] KIND_TRUE     = 4'd9;
   localparam logic [3:0] KIND_STRCHAR  = 4'd10;
   localparam logic [3:0] KIND_STREND   = 4'd11;
   localparam logic [3:0] KIND_NUMCHAR  = 4'd12;
   localparam logic [3:0] KIND_NUMEND   = 4'd13;
   localparam logic [3:0] KIND_ERROR    = 4'd14;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
   localparam logic [2:0] ERR_NUMBER     = 3'd2;
   localparam logic [2:0] ERR_UNTERM_STR = 3'd3;
   localparam logic [2:0] ERR_UNTERM_ESC = 3'd4;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd5;

   // Keyword tails after the first letter; the fourth slot of the short words is never read.
   localparam logic [15:0] KW_NULL  [4] = '{16'h0075, 16'h006C, 16'h006C, 16'h0000};
   localparam logic [15:0] KW_FALSE [4] = '{16'h0061, 16'h006C, 16'h0073, 16'h0065};
   localparam logic [15:0] KW_TRUE  [4] = '{16'h0072, 16'h0075, 16'h0065, 16'h0000};

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] unit_value;
      logic [31:0] token_position;
      logic [2:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       ws;
      logic [3:0] punct_kind;
      logic       digit;
      logic       minus;
      logic       plus;
      logic       dot;
      logic       expo;
      logic       quote;
      logic       bslash;
      logic       start_n;
      logic       start_f;
      logic       start_t;
      logic       esc_ok;
      logic       esc_u;
      logic       hex_ok;
      logic [6:0] esc_val;
      logic [3:0] hex_val;
   } class_type;

   typedef struct packed {
      req_type   req;
      class_type cls;
   } item_type;

   typedef struct packed {
      logic [1:0]         count;
      rsp_type [1:0]      data;
   } wr_type;

   function automatic class_type classify(input logic [15:0] c);
      class_type k;
      k = '0;
      k.ws      = (c inside {16'h0009, 16'h000A, 16'h000D, 16'h0020});
      k.digit   = (c inside {[16'h0030:16'h0039]});
      k.minus   = (c == 16'h002D);
      k.plus    = (c == 16'h002B);
      k.dot     = (c == 16'h002E);
      k.expo    = (c inside {16'h0065, 16'h0045});
      k.quote   = (c == 16'h0022);
      k.bslash  = (c == 16'h005C);
      k.start_n = (c == 16'h006E);
      k.start_f = (c == 16'h0066);
      k.start_t = (c == 16'h0074);
      k.esc_u   = (c == 16'h0075);
      case (c)
         16'h005B: k.punct_kind = KIND_LBRACKET;
         16'h005D: k.punct_kind = KIND_RBRACKET;
         16'h007B: k.punct_kind = KIND_LBRACE;
         16'h007D: k.punct_kind = KIND_RBRACE;
         16'h002C: k.punct_kind = KIND_COMMA;
         16'h003A: k.punct_kind = KIND_COLON;
         default:  k.punct_kind = 4'd0;
      endcase
      k.esc_ok = 1'b1;
      case (c)
         16'h0022: k.esc_val = 7'h22;
         16'h002F: k.esc_val = 7'h2F;
         16'h005C: k.esc_val = 7'h5C;
         16'h0062: k.esc_val = 7'h08;
         16'h0066: k.esc_val = 7'h0C;
         16'h006E: k.esc_val = 7'h0A;
         16'h0072: k.esc_val = 7'h0D;
         16'h0074: k.esc_val = 7'h09;
         default: begin
            k.esc_ok  = 1'b0;
            k.esc_val = 7'h00;
         end
      endcase
      // Letters a-f and A-F both carry their value minus nine in the low nibble.
      k.hex_ok = k.digit || (c inside {[16'h0061:16'h0066], [16'h0041:16'h0046]});
      k.hex_val = k.digit ? c[3:0] : c[3:0] + 4'd9;
      return k;
   endfunction

endpackage

### design/jts_front.sv
// Front end of the JSON token scanner: accepts requests, classifies each code unit
// and holds them in a short queue for the back end. Uses jts_pkg.
module jts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  jts_pkg::req_type  req_data,
   output logic              head_valid,
   output jts_pkg::item_type head_item,
   input  logic              head_pop
);

   localparam int DEPTH = jts_pkg::IN_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   jts_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              write_en;

   assign full       = (count_ff == CW'(DEPTH));
   assign write_en   = push && !full;
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (write_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (write_en && !head_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!write_en && head_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[wr_ptr_ff].req <= req_data;
         mem_ff[wr_ptr_ff].cls <= jts_pkg::classify(req_data.code_unit);
      end
   end

endmodule

### design/jts_back.sv
// Back end of the JSON token scanner: the scan state machine that turns one classified
// request into zero, one or two results. Uses jts_pkg.
module jts_back #(
   parameter int POS_WIDTH = jts_pkg::POS_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  jts_pkg::item_type in_item,
   output logic              in_take,
   input  logic              out_room,
   output jts_pkg::wr_type   out_wr
);

   localparam int PW = POS_WIDTH;

   typedef enum logic [3:0] {
      M_IDLE, M_KNULL, M_KFALSE, M_KTRUE, M_NEG, M_INT, M_FRNEED, M_FRAC,
      M_EXSIGN, M_EXNEED, M_EXP, M_STR, M_ESC, M_HEX
   } mode_type;

   mode_type       mode_ff, mode_in;
   logic [3:0]     kp_ff, kp_in;
   logic [1:0]     hc_ff, hc_in;
   logic [15:0]    acc_ff, acc_in;
   logic           ejd_ff, ejd_in;
   logic           err_ff, err_in;
   logic [PW-1:0]  start_ff, start_in;
   logic [PW-1:0]  pos_ff, pos_in;

   logic [15:0]    c;
   jts_pkg::class_type cls;
   logic [15:0]    kw_letter;
   logic [3:0]     kw_len;
   logic [3:0]     kw_kind;
   logic [15:0]    acc_next;
   logic           run_idle;
   logic           fail_now;
   logic [2:0]     fail_code;
   logic [PW-1:0]  fail_pos;
   logic           num_ok;
   logic           num_end;
   mode_type       num_next;
   logic [1:0]     cnt;
   jts_pkg::rsp_type [1:0] res;

   function automatic jts_pkg::rsp_type make_rsp(input logic [3:0] k, input logic [15:0] v,
                                                  input logic [PW-1:0] ps, input logic [2:0] e);
      jts_pkg::rsp_type r;
      logic [PW+31:0]   wide;
      wide             = {32'd0, ps};
      r.token_kind     = k;
      r.unit_value     = v;
      r.token_position = wide[31:0];
      r.error_code     = e;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   assign in_take  = in_valid && out_room;
   assign c        = in_item.req.code_unit;
   assign cls      = in_item.cls;
   assign acc_next = {acc_ff[11:0], cls.hex_val};

   always_comb begin
      case (mode_ff)
         M_KFALSE: begin
            kw_letter = jts_pkg::KW_FALSE[kp_ff[1:0]];
            kw_len    = 4'd4;
            kw_kind   = jts_pkg::KIND_FALSE;
         end
         M_KTRUE: begin
            kw_letter = jts_pkg::KW_TRUE[kp_ff[1:0]];
            kw_len    = 4'd3;
            kw_kind   = jts_pkg::KIND_TRUE;
         end
         default: begin
            kw_letter = jts_pkg::KW_NULL[kp_ff[1:0]];
            kw_len    = 4'd3;
            kw_kind   = jts_pkg::KIND_NULL;
         end
      endcase
   end

   // Number grammar: which characters continue the number and where it goes next.
   always_comb begin
      num_ok   = 1'b0;
      num_end  = 1'b0;
      num_next = mode_ff;
      case (mode_ff)
         M_NEG: begin
            num_ok   = cls.digit;
            num_next = M_INT;
         end
         M_FRNEED: begin
            num_ok   = cls.digit;
            num_next = M_FRAC;
         end
         M_EXNEED: begin
            num_ok   = cls.digit;
            num_next = M_EXP;
         end
         M_INT: begin
            num_ok   = cls.digit || cls.dot || cls.expo;
            num_end  = !num_ok;
            num_next = cls.digit ? M_INT : (cls.dot ? M_FRNEED : M_EXSIGN);
         end
         M_FRAC: begin
            num_ok   = cls.digit || cls.expo;
            num_end  = !num_ok;
            num_next = cls.digit ? M_FRAC : M_EXSIGN;
         end
         M_EXSIGN: begin
            num_ok   = cls.digit || cls.plus || cls.minus;
            num_next = cls.digit ? M_EXP : M_EXNEED;
         end
         M_EXP: begin
            num_ok   = cls.digit;
            num_end  = !num_ok;
            num_next = M_EXP;
         end
         default: begin
            num_ok   = 1'b0;
            num_end  = 1'b0;
            num_next = mode_ff;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      kp_in     = kp_ff;
      hc_in     = hc_ff;
      acc_in    = acc_ff;
      ejd_in    = ejd_ff;
      err_in    = err_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      cnt       = 2'd0;
      res       = '0;
      run_idle  = 1'b0;
      fail_now  = 1'b0;
      fail_code = jts_pkg::ERR_NONE;
      fail_pos  = start_ff;
      if (in_take) begin
         if (in_item.req.end_of_text) begin
            if (!err_ff) begin
               case (mode_ff)
                  M_KNULL, M_KFALSE, M_KTRUE: begin
                     fail_now  = 1'b1;
                     fail_code = jts_pkg::ERR_UNEXPECTED;
                  end
                  M_INT, M_FRAC, M_EXP: begin
                     res[cnt[0]] = make_rsp(jts_pkg::KIND_NUMEND, 16'd0, start_ff,
                                            jts_pkg::ERR_NONE);
                     cnt = cnt + 2'd1;
                  end
                  M_NEG, M_FRNEED, M_EXSIGN, M_EXNEED: begin
                     fail_now  = 1'b1;
                     fail_code = jts_pkg::ERR_NUMBER;
                  end
                  M_STR: begin
                     fail_now = 1'b1;
                     if (ejd_ff) begin
                        // A finished escape was the last character: point back at its letter.
                        fail_code = jts_pkg::ERR_UNTERM_ESC;
                        fail_pos  = pos_ff - PW'(kp_ff);
                     end else begin
                        fail_code = jts_pkg::ERR_UNTERM_STR;
                     end
                  end
                  M_ESC: begin
                     fail_now  = 1'b1;
                     fail_code = jts_pkg::ERR_UNTERM_STR;
                  end
                  M_HEX: begin
                     fail_now  = 1'b1;
                     fail_code = jts_pkg::ERR_UNTERM_ESC;
                     fail_pos  = pos_ff - PW'(hc_ff) - PW'(1);
                  end
                  default: begin
                     fail_now = 1'b0;
                  end
               endcase
            end
         end else begin
            if (pos_ff != {PW{1'b1}}) begin
               pos_in = pos_ff + PW'(1);
            end
            if (!err_ff) begin
               case (mode_ff)
                  M_IDLE: begin
                     run_idle = 1'b1;
                  end
                  M_KNULL, M_KFALSE, M_KTRUE: begin
                     if (kp_ff >= kw_len || c != kw_letter) begin
                        fail_now  = 1'b1;
                        fail_code = jts_pkg::ERR_UNEXPECTED;
                     end else if (kp_ff + 4'd1 == kw_len) begin
                        res[cnt[0]] = make_rsp(kw_kind, 16'd0, start_ff, jts_pkg::ERR_NONE);
                        cnt     = cnt + 2'd1;
                        mode_in = M_IDLE;
                        kp_in   = 4'd0;
                        hc_in   = 2'd0;
                        acc_in  = 16'd0;
                        ejd_in  = 1'b0;
                     end else begin
                        kp_in = kp_ff + 4'd1;
                     end
                  end
                  M_STR: begin
                     ejd_in = 1'b0;
                     kp_in  = 4'd0;
                     if (cls.quote) begin
                        res[cnt[0]] = make_rsp(jts_pkg::KIND_STREND, 16'd0, start_ff,
                                               jts_pkg::ERR_NONE);
                        cnt     = cnt + 2'd1;
                        mode_in = M_IDLE;
                        hc_in   = 2'd0;
                        acc_in  = 16'd0;
                     end else if (cls.bslash) begin
                        mode_in = M_ESC;
                     end else begin
                        res[cnt[0]] = make_rsp(jts_pkg::KIND_STRCHAR, c, start_ff,
                                               jts_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                  end
                  M_ESC: begin
                     if (cls.esc_u) begin
                        mode_in = M_HEX;
                        hc_in   = 2'd0;
                        acc_in  = 16'd0;
                     end else if (cls.esc_ok) begin
                        res[cnt[0]] = make_rsp(jts_pkg::KIND_STRCHAR, {9'd0, cls.esc_val},
                                               start_ff, jts_pkg::ERR_NONE);
                        cnt     = cnt + 2'd1;
                        mode_in = M_STR;
                        ejd_in  = 1'b1;
                        kp_in   = 4'd1;
                     end else begin
                        fail_now  = 1'b1;
                        fail_code = jts_pkg::ERR_BAD_ESC;
                        fail_pos  = pos_ff;
                     end
                  end
                  M_HEX: begin
                     if (!cls.hex_ok) begin
                        fail_now  = 1'b1;
                        fail_code = jts_pkg::ERR_BAD_ESC;
                        fail_pos  = pos_ff - PW'(hc_ff) - PW'(1);
                     end else begin
                        acc_in = acc_next;
                        if (hc_ff == 2'd3) begin
                           res[cnt[0]] = make_rsp(jts_pkg::KIND_STRCHAR, acc_next, start_ff,
                                                  jts_pkg::ERR_NONE);
                           cnt     = cnt + 2'd1;
                           mode_in = M_STR;
                           hc_in   = 2'd0;
                           ejd_in  = 1'b1;
                           kp_in   = 4'd5;
                        end else begin
                           hc_in = hc_ff + 2'd1;
                        end
                     end
                  end
                  default: begin
                     if (num_ok) begin
                        res[cnt[0]] = make_rsp(jts_pkg::KIND_NUMCHAR, c, start_ff,
                                               jts_pkg::ERR_NONE);
                        cnt     = cnt + 2'd1;
                        mode_in = num_next;
                     end else if (num_end) begin
                        // The number closes here and this character is scanned again.
                        res[cnt[0]] = make_rsp(jts_pkg::KIND_NUMEND, 16'd0, start_ff,
                                               jts_pkg::ERR_NONE);
                        cnt      = cnt + 2'd1;
                        mode_in  = M_IDLE;
                        kp_in    = 4'd0;
                        hc_in    = 2'd0;
                        acc_in   = 16'd0;
                        ejd_in   = 1'b0;
                        run_idle = 1'b1;
                     end else begin
                        fail_now  = 1'b1;
                        fail_code = jts_pkg::ERR_NUMBER;
                     end
                  end
               endcase
            end
         end

         if (run_idle) begin
            start_in = pos_ff;
            if (cls.ws) begin
               start_in = pos_ff;
            end else if (cls.punct_kind != 4'd0) begin
               res[cnt[0]] = make_rsp(cls.punct_kind, 16'd0, pos_ff, jts_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
            end else if (cls.start_n) begin
               mode_in = M_KNULL;
               kp_in   = 4'd0;
            end else if (cls.start_f) begin
               mode_in = M_KFALSE;
               kp_in   = 4'd0;
            end else if (cls.start_t) begin
               mode_in = M_KTRUE;
               kp_in   = 4'd0;
            end else if (cls.quote) begin
               mode_in = M_STR;
               ejd_in  = 1'b0;
            end else if (cls.minus || cls.digit) begin
               res[cnt[0]] = make_rsp(jts_pkg::KIND_NUMCHAR, c, pos_ff, jts_pkg::ERR_NONE);
               cnt     = cnt + 2'd1;
               mode_in = cls.minus ? M_NEG : M_INT;
            end else begin
               fail_now  = 1'b1;
               fail_code = jts_pkg::ERR_UNEXPECTED;
               fail_pos  = pos_ff;
            end
         end

         if (fail_now) begin
            res[cnt[0]] = make_rsp(jts_pkg::KIND_ERROR, 16'd0, fail_pos, fail_code);
            cnt     = cnt + 2'd1;
            mode_in = M_IDLE;
            kp_in   = 4'd0;
            hc_in   = 2'd0;
            acc_in  = 16'd0;
            ejd_in  = 1'b0;
            err_in  = 1'b1;
         end

         if (in_item.req.end_of_text) begin
            res[cnt[0]] = make_rsp(jts_pkg::KIND_EOF, 16'd0, pos_ff, jts_pkg::ERR_NONE);
            cnt      = cnt + 2'd1;
            mode_in  = M_IDLE;
            kp_in    = 4'd0;
            hc_in    = 2'd0;
            acc_in   = 16'd0;
            ejd_in   = 1'b0;
            err_in   = 1'b0;
            start_in = '0;
            pos_in   = '0;
         end

         if (cnt == 2'd2) begin
            res[1].last_of_run = 1'b1;
         end else if (cnt == 2'd1) begin
            res[0].last_of_run = 1'b1;
         end
      end
      out_wr.count = cnt;
      out_wr.data  = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         kp_ff    <= 4'd0;
         hc_ff    <= 2'd0;
         acc_ff   <= 16'd0;
         ejd_ff   <= 1'b0;
         err_ff   <= 1'b0;
         start_ff <= '0;
         pos_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         kp_ff    <= kp_in;
         hc_ff    <= hc_in;
         acc_ff   <= acc_in;
         ejd_ff   <= ejd_in;
         err_ff   <= err_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

### design/jts_out_queue.sv
// Result queue of the JSON token scanner: takes up to two results a cycle from the
// back end and hands them out one at a time, oldest first. Uses jts_pkg.
module jts_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  jts_pkg::wr_type  wr,
   output logic             room,
   output logic             empty,
   input  logic             pop,
   output jts_pkg::rsp_type rsp_data
);

   localparam int DEPTH = jts_pkg::OUT_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   jts_pkg::rsp_type mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop_en;
   logic [AW-1:0]    wr_ptr_next;

   // Pointers wrap naturally; the depth is a power of two.
   assign wr_ptr_next = wr_ptr_ff + AW'(1);
   assign empty       = (count_ff == '0);
   assign room        = (count_ff <= CW'(DEPTH - 2));
   assign pop_en      = pop && !empty;
   assign rsp_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(wr.count);
      rd_ptr_in = pop_en ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(wr.count) - CW'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr.data[0];
      end
      if (wr.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= wr.data[1];
      end
   end

endmodule

### design/json_token_scanner.sv
// Top level of the JSON token scanner: request queue with classifier, scan engine
// and result queue. Uses jts_pkg, jts_front, jts_back and jts_out_queue.
//
//   channel   handshake          payload              direction
//   request   push / full        req_data (req_type)  in
//   result    empty / pop        rsp_data (rsp_type)  out
//
// The scan engine takes one code unit per clock while the result queue has room.
// A request shows up as results in the cycle after it is taken at the earliest.
// Each result needs its own pop, so a unit that gives two results needs two pops.
// The scan engine waits while the result queue has fewer than two free entries;
// the request queue then fills and full rises once it holds four requests.
// Reset is synchronous and leaves both queues empty and the scanner between tokens.
module json_token_scanner #(
   parameter int POS_WIDTH = jts_pkg::POS_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  jts_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output jts_pkg::rsp_type rsp_data
);

   logic              head_valid;
   jts_pkg::item_type head_item;
   logic              head_take;
   logic              out_room;
   jts_pkg::wr_type   out_wr;

   jts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_take)
   );

   jts_back #(
      .POS_WIDTH (POS_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (head_valid),
      .in_item  (head_item),
      .in_take  (head_take),
      .out_room (out_room),
      .out_wr   (out_wr)
   );

   jts_out_queue u_out (
      .clock    (clock),
      .reset    (reset),
      .wr       (out_wr),
      .room     (out_room),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

### design/jts_checker.sv
// Port-level checks for the JSON token scanner, bound to the top level.
// Uses jts_pkg and sees only the ports of json_token_scanner.
module jts_checker (
   input logic             clock,
   input logic             reset,
   input logic             push,
   input logic             full,
   input jts_pkg::req_type req_data,
   input logic             empty,
   input logic             pop,
   input jts_pkg::rsp_type rsp_data
);

   // The result queue comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   // A waiting result that is not taken stays unchanged.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed before it was taken");

   // Error results, and only they, carry an error code.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_data.token_kind == jts_pkg::KIND_ERROR) ==
                  (rsp_data.error_code != jts_pkg::ERR_NONE)))
      else $error("error code does not match token kind");

   // End of text is always the final result of its request.
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.token_kind == jts_pkg::KIND_EOF) |-> rsp_data.last_of_run)
      else $error("eof result not marked last of run");

   // Only string and number characters carry a unit value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.token_kind != jts_pkg::KIND_STRCHAR &&
       rsp_data.token_kind != jts_pkg::KIND_NUMCHAR) |-> (rsp_data.unit_value == 16'd0))
      else $error("unit value set on a token without one");

endmodule

bind json_token_scanner jts_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .req_data (req_data),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
